[rtl/core/apad_pkg.sv]
// Shared types, widths, register codes and reset values for the active
// picture area detector. No dependencies; every other file imports this one.
`default_nettype none

package apad_pkg;

  // Field widths of the pixel, result and configuration beats.
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int LUMA_W     = 8;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Defaults for the top-level parameters.
  localparam int MAX_DIM_DEF     = 4096;
  localparam int SAMPLE_STEP_DEF = 4;
  localparam int DARK_STEP_DEF   = 64;

  // Register values after reset.
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd720;
  localparam logic [LUMA_W-1:0] LUMA_THRESH_RST  = 8'd40;
  localparam logic [DIM_W-1:0]  MIN_WIDTH_RST    = 13'd700;
  localparam logic [DIM_W-1:0]  MIN_HEIGHT_RST   = 13'd420;
  localparam logic [CNT_W-1:0]  ACCUM_FRAMES_RST = 8'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_LUMA_THRESHOLD = 3'd2,
    CFG_MIN_WIDTH      = 3'd3,
    CFG_MIN_HEIGHT     = 3'd4,
    CFG_ACCUM_FRAMES   = 3'd5
  } cfg_idx_t;

  // Per-frame status codes reported on every frame-end beat.
  typedef enum logic [2:0] {
    ST_LOCKED_ALREADY = 3'd0,
    ST_DARK           = 3'd1,
    ST_EDGE_MISSING   = 3'd2,
    ST_ACCUMULATED    = 3'd3,
    ST_LOCKED_NOW     = 3'd4,
    ST_TOO_SMALL      = 3'd5
  } status_t;

  // Configuration as seen by the datapath, with the border bands precomputed.
  typedef struct packed {
    logic [DIM_W-1:0]  w_eff;     // frame width clamped to the maximum
    logic [DIM_W-1:0]  h_eff;     // frame height clamped to the maximum
    logic [LUMA_W-1:0] luma_thr;
    logic [DIM_W-1:0]  min_w;
    logic [DIM_W-1:0]  min_h;
    logic [CNT_W-1:0]  accum;
    logic [DIM_W-1:0]  xb;        // last column of the left band
    logic [DIM_W-1:0]  yb;        // last line of the top band
    logic [DIM_W-1:0]  right_lo;  // first column of the right band
    logic [DIM_W-1:0]  bot_lo;    // first line of the bottom band
  } cfg_t;

  // Bright bounds collected over one frame.
  typedef struct packed {
    logic               light;
    logic               top_found;
    logic [COORD_W-1:0] top_line;
    logic               bot_found;
    logic [COORD_W-1:0] bot_line;
    logic               left_found;
    logic [COORD_W-1:0] left_col;
    logic               right_found;
    logic [COORD_W-1:0] right_col;
  } frame_sum_t;

  // Band depth minus one: size - min when size exceeds min, else zero.
  function automatic logic [DIM_W-1:0] band_fn(input logic [DIM_W-1:0] size,
                                               input logic [DIM_W-1:0] minv);
    return (size > minv) ? (size - minv) : '0;
  endfunction

  // First coordinate of the far band: size - band - 1, floored at zero.
  function automatic logic [DIM_W-1:0] far_lo_fn(input logic [DIM_W-1:0] size,
                                                 input logic [DIM_W-1:0] bnd);
    return (size > bnd) ? (size - bnd - DIM_W'(1)) : '0;
  endfunction

endpackage

`default_nettype wire

[rtl/core/apad_cfg.sv]
// Configuration register file of the active picture area detector, with the
// derived frame size and border bands kept in registers. Uses apad_pkg.
`default_nettype none

module apad_cfg import apad_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [DIM_W:0] MAX_DIM_V = (DIM_W+1)'(MAX_DIM);

  logic [DIM_W-1:0]  fw_r, fw_nxt;
  logic [DIM_W-1:0]  fh_r, fh_nxt;
  logic [LUMA_W-1:0] thr_r, thr_nxt;
  logic [DIM_W-1:0]  minw_r, minw_nxt;
  logic [DIM_W-1:0]  minh_r, minh_nxt;
  logic [CNT_W-1:0]  accum_r, accum_nxt;
  cfg_t              cfg_r, cfg_nxt;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return ({1'b0, v} > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : v;
  endfunction

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write decode, with synchronous reset folded in.
  always_comb begin
    fw_nxt    = fw_r;
    fh_nxt    = fh_r;
    thr_nxt   = thr_r;
    minw_nxt  = minw_r;
    minh_nxt  = minh_r;
    accum_nxt = accum_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:    fw_nxt    = cfg_data;
        CFG_FRAME_HEIGHT:   fh_nxt    = cfg_data;
        CFG_LUMA_THRESHOLD: thr_nxt   = cfg_data[LUMA_W-1:0];
        CFG_MIN_WIDTH:      minw_nxt  = cfg_data;
        CFG_MIN_HEIGHT:     minh_nxt  = cfg_data;
        CFG_ACCUM_FRAMES:   accum_nxt = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
    if (!rst_n) begin
      fw_nxt    = FRAME_WIDTH_RST;
      fh_nxt    = FRAME_HEIGHT_RST;
      thr_nxt   = LUMA_THRESH_RST;
      minw_nxt  = MIN_WIDTH_RST;
      minh_nxt  = MIN_HEIGHT_RST;
      accum_nxt = ACCUM_FRAMES_RST;
    end
  end

  // Derived values follow the register values of the same edge.
  always_comb begin
    cfg_nxt.w_eff    = eff_dim(fw_nxt);
    cfg_nxt.h_eff    = eff_dim(fh_nxt);
    cfg_nxt.luma_thr = thr_nxt;
    cfg_nxt.min_w    = minw_nxt;
    cfg_nxt.min_h    = minh_nxt;
    cfg_nxt.accum    = accum_nxt;
    cfg_nxt.xb       = band_fn(cfg_nxt.w_eff, minw_nxt);
    cfg_nxt.yb       = band_fn(cfg_nxt.h_eff, minh_nxt);
    cfg_nxt.right_lo = far_lo_fn(cfg_nxt.w_eff, cfg_nxt.xb);
    cfg_nxt.bot_lo   = far_lo_fn(cfg_nxt.h_eff, cfg_nxt.yb);
  end

  always_ff @(posedge clk) begin
    fw_r    <= fw_nxt;
    fh_r    <= fh_nxt;
    thr_r   <= thr_nxt;
    minw_r  <= minw_nxt;
    minh_r  <= minh_nxt;
    accum_r <= accum_nxt;
    cfg_r   <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/core/apad_track.sv]
// Per-pixel front end: input register with luma and grid-sample decode, then
// the running bright bounds of the current frame. Uses apad_pkg.
`default_nettype none

module apad_track import apad_pkg::*; #(
  parameter int SAMPLE_STEP = SAMPLE_STEP_DEF,
  parameter int DARK_STEP   = DARK_STEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               pix_valid,
  input  logic [LUMA_W-1:0]  pix_blue,
  input  logic [LUMA_W-1:0]  pix_green,
  input  logic [LUMA_W-1:0]  pix_red,
  input  logic [COORD_W-1:0] pix_col,
  input  logic [COORD_W-1:0] pix_row,
  input  logic               pix_frame_end,
  input  cfg_t               cfg,
  output logic               sum_valid,
  output frame_sum_t         sum
);

  // Divisibility by a constant: x is a multiple of d exactly when the low
  // F bits of x * ceil(2^F / d) fall below that multiplier.
  localparam int SF = COORD_W + 1 + $clog2(SAMPLE_STEP);
  localparam int SM = ((1 << SF) + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam logic [SF:0] SMV = (SF+1)'(SM);
  localparam int DF = COORD_W + 1 + $clog2(DARK_STEP);
  localparam int DM = ((1 << DF) + DARK_STEP - 1) / DARK_STEP;
  localparam logic [DF:0] DMV = (DF+1)'(DM);

  logic [SF+COORD_W:0] col_sp, row_sp;
  logic [DF+COORD_W:0] col_dp, row_dp;
  logic [LUMA_W-1:0]   bg_max, luma;

  logic               v_r;
  logic [LUMA_W-1:0]  luma_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic               fe_r;
  logic               col_samp_r, row_samp_r, col_dark_r, row_dark_r;

  frame_sum_t cur_r, upd;
  frame_sum_t sum_r;
  logic       sum_valid_r;
  logic       bright;

  // Input side: brightest channel and the sample-grid flags.
  assign bg_max = (pix_green > pix_blue) ? pix_green : pix_blue;
  assign luma   = (pix_red > bg_max) ? pix_red : bg_max;
  assign col_sp = {{(SF+1){1'b0}}, pix_col} * {{COORD_W{1'b0}}, SMV};
  assign row_sp = {{(SF+1){1'b0}}, pix_row} * {{COORD_W{1'b0}}, SMV};
  assign col_dp = {{(DF+1){1'b0}}, pix_col} * {{COORD_W{1'b0}}, DMV};
  assign row_dp = {{(DF+1){1'b0}}, pix_row} * {{COORD_W{1'b0}}, DMV};

  always_ff @(posedge clk) begin
    if (adv && pix_valid) begin
      luma_r     <= luma;
      col_r      <= pix_col;
      row_r      <= pix_row;
      fe_r       <= pix_frame_end;
      col_samp_r <= ({1'b0, col_sp[SF-1:0]} < SMV);
      row_samp_r <= ({1'b0, row_sp[SF-1:0]} < SMV);
      col_dark_r <= ({1'b0, col_dp[DF-1:0]} < DMV);
      row_dark_r <= ({1'b0, row_dp[DF-1:0]} < DMV);
    end
  end

  // Bound update for the registered pixel.
  always_comb begin
    bright = (luma_r > cfg.luma_thr) &&
             ({1'b0, col_r} < cfg.w_eff) && ({1'b0, row_r} < cfg.h_eff);
    upd = cur_r;
    if (bright && col_dark_r && row_dark_r) begin
      upd.light = 1'b1;
    end
    if (bright && col_samp_r && ({1'b0, row_r} <= cfg.yb) &&
        (!cur_r.top_found || row_r < cur_r.top_line)) begin
      upd.top_found = 1'b1;
      upd.top_line  = row_r;
    end
    if (bright && col_samp_r && ({1'b0, row_r} >= cfg.bot_lo) &&
        (!cur_r.bot_found || row_r > cur_r.bot_line)) begin
      upd.bot_found = 1'b1;
      upd.bot_line  = row_r;
    end
    if (bright && row_samp_r && ({1'b0, col_r} <= cfg.xb) &&
        (!cur_r.left_found || col_r < cur_r.left_col)) begin
      upd.left_found = 1'b1;
      upd.left_col   = col_r;
    end
    if (bright && row_samp_r && ({1'b0, col_r} >= cfg.right_lo) &&
        (!cur_r.right_found || col_r > cur_r.right_col)) begin
      upd.right_found = 1'b1;
      upd.right_col   = col_r;
    end
  end

  // Trackers restart after a frame-end pixel; its summary goes downstream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= 1'b0;
      sum_valid_r <= 1'b0;
      cur_r       <= '0;
    end else if (adv) begin
      v_r         <= pix_valid;
      sum_valid_r <= v_r && fe_r;
      if (v_r) begin
        cur_r <= fe_r ? '0 : upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r && fe_r) begin
      sum_r <= upd;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

endmodule

`default_nettype wire

[rtl/core/active_picture_area_detector.sv]
// Top level of the active picture area detector: configuration, pixel
// tracking and the per-frame lock decision. Uses apad_pkg, apad_cfg, apad_track.
`default_nettype none

// Takes one pixel beat per clock while in_stall is low and returns one result
// beat for every pixel that carries frame_end, once that pixel has passed
// the input register, the bound tracker and the decision stage with its
// result register. Pixels without frame_end give no result. The result
// register holds a beat while out_stall is high and pixels keep flowing
// meanwhile; in_stall rises only when a second frame-end summary reaches
// the decision stage while the earlier result has not been taken. The user
// must make configuration writes while no frame is in flight; the block does
// not enforce this. Once a rectangle is locked it stays locked until reset.
module active_picture_area_detector import apad_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int SAMPLE_STEP = SAMPLE_STEP_DEF,
  parameter int DARK_STEP   = DARK_STEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel beats.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LUMA_W-1:0]     in_blue,
  input  logic [LUMA_W-1:0]     in_green,
  input  logic [LUMA_W-1:0]     in_red,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [COORD_W-1:0]    in_row,
  input  logic                  in_frame_end,
  // Result beats.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_frame_status,
  output logic                  out_rect_valid,
  output logic [COORD_W-1:0]    out_rect_x,
  output logic [COORD_W-1:0]    out_rect_y,
  output logic [DIM_W-1:0]      out_rect_w,
  output logic [DIM_W-1:0]      out_rect_h,
  output logic [CNT_W-1:0]      out_frames_accumulated,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  frame_sum_t sum;
  logic       sum_valid;
  logic       hold, fire;

  logic               locked_r, locked_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt, acc_inc;
  logic [COORD_W-1:0] ut_r, ut_nxt, ub_r, ub_nxt, ul_r, ul_nxt, ur_r, ur_nxt;
  logic [COORD_W-1:0] ut_m, ub_m, ul_m, ur_m;
  logic [COORD_W-1:0] lx_r, lx_nxt, ly_r, ly_nxt;
  logic [DIM_W-1:0]   lw_r, lw_nxt, lh_r, lh_nxt;
  logic [DIM_W:0]     aw, ah;
  logic               size_ok;
  status_t            status_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_rv_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [DIM_W-1:0]   out_w_r, out_h_r;
  logic [CNT_W-1:0]   out_acc_r;

  apad_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  apad_track #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .DARK_STEP   (DARK_STEP)
  ) u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (!hold),
    .pix_valid     (in_valid),
    .pix_blue      (in_blue),
    .pix_green     (in_green),
    .pix_red       (in_red),
    .pix_col       (in_col),
    .pix_row       (in_row),
    .pix_frame_end (in_frame_end),
    .cfg           (cfg),
    .sum_valid     (sum_valid),
    .sum           (sum)
  );

  // The whole pipe freezes only when a summary waits on a held result.
  assign hold     = sum_valid && out_valid_r && out_stall;
  assign fire     = sum_valid && !hold;
  assign in_stall = hold;

  // Union of this frame's bounds with the running one, and its size.
  always_comb begin
    ut_m = (acc_r == '0 || sum.top_line < ut_r)  ? sum.top_line  : ut_r;
    ub_m = (acc_r == '0 || sum.bot_line > ub_r)  ? sum.bot_line  : ub_r;
    ul_m = (acc_r == '0 || sum.left_col < ul_r)  ? sum.left_col  : ul_r;
    ur_m = (acc_r == '0 || sum.right_col > ur_r) ? sum.right_col : ur_r;
    aw   = {2'b00, ur_m} - {2'b00, ul_m} + (DIM_W+1)'(1);
    ah   = {2'b00, ub_m} - {2'b00, ut_m} + (DIM_W+1)'(1);
    // A negative span has the top bit set and never passes.
    size_ok = !aw[DIM_W] && !ah[DIM_W] && (aw != '0) && (ah != '0) &&
              (aw >= {1'b0, cfg.min_w}) && (ah >= {1'b0, cfg.min_h});
  end

  // Frame decision.
  always_comb begin
    acc_inc    = acc_r + CNT_W'(1);
    status_nxt = ST_LOCKED_ALREADY;
    locked_nxt = locked_r;
    acc_nxt    = acc_r;
    ut_nxt     = ut_r;
    ub_nxt     = ub_r;
    ul_nxt     = ul_r;
    ur_nxt     = ur_r;
    lx_nxt     = lx_r;
    ly_nxt     = ly_r;
    lw_nxt     = lw_r;
    lh_nxt     = lh_r;
    priority if (locked_r) begin
      status_nxt = ST_LOCKED_ALREADY;
    end else if (!sum.light) begin
      status_nxt = ST_DARK;
    end else if (!(sum.top_found && sum.bot_found && sum.left_found &&
                   sum.right_found)) begin
      status_nxt = ST_EDGE_MISSING;
    end else begin
      ut_nxt  = ut_m;
      ub_nxt  = ub_m;
      ul_nxt  = ul_m;
      ur_nxt  = ur_m;
      acc_nxt = acc_inc;
      priority if (acc_inc < cfg.accum) begin
        status_nxt = ST_ACCUMULATED;
      end else if (size_ok) begin
        status_nxt = ST_LOCKED_NOW;
        locked_nxt = 1'b1;
        lx_nxt     = ul_m;
        ly_nxt     = ut_m;
        lw_nxt     = aw[DIM_W-1:0];
        lh_nxt     = ah[DIM_W-1:0];
      end else begin
        status_nxt = ST_TOO_SMALL;
        acc_nxt    = '0;
      end
    end
  end

  // Decision state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      locked_r    <= locked_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Union, locked rectangle and result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      ut_r         <= ut_nxt;
      ub_r         <= ub_nxt;
      ul_r         <= ul_nxt;
      ur_r         <= ur_nxt;
      lx_r         <= lx_nxt;
      ly_r         <= ly_nxt;
      lw_r         <= lw_nxt;
      lh_r         <= lh_nxt;
      out_status_r <= status_nxt;
      out_rv_r     <= locked_nxt;
      out_x_r      <= locked_nxt ? lx_nxt : '0;
      out_y_r      <= locked_nxt ? ly_nxt : '0;
      out_w_r      <= locked_nxt ? lw_nxt : cfg.w_eff;
      out_h_r      <= locked_nxt ? lh_nxt : cfg.h_eff;
      out_acc_r    <= acc_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_status       = out_status_r;
  assign out_rect_valid         = out_rv_r;
  assign out_rect_x             = out_x_r;
  assign out_rect_y             = out_y_r;
  assign out_rect_w             = out_w_r;
  assign out_rect_h             = out_h_r;
  assign out_frames_accumulated = out_acc_r;

endmodule

`default_nettype wire

[rtl/core/apad_checker.sv]
// Port-level checks for the active picture area detector, bound to the top
// level. Uses apad_pkg and the ports of active_picture_area_detector.
`default_nettype none

module apad_checker import apad_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            out_frame_status,
  input logic                  out_rect_valid,
  input logic [COORD_W-1:0]    out_rect_x,
  input logic [COORD_W-1:0]    out_rect_y,
  input logic [DIM_W-1:0]      out_rect_w,
  input logic [DIM_W-1:0]      out_rect_h,
  input logic [CNT_W-1:0]      out_frames_accumulated
);

  // A held result beat keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame_status) &&
      $stable(out_rect_valid) && $stable(out_rect_x) && $stable(out_rect_y) &&
      $stable(out_rect_w) && $stable(out_rect_h) &&
      $stable(out_frames_accumulated)))
    else $error("result beat changed while stalled");

  // A locked rectangle is reported only with a locked status.
  a_lock_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rect_valid) |->
      (out_frame_status == ST_LOCKED_NOW || out_frame_status == ST_LOCKED_ALREADY))
    else $error("rectangle valid with an unlocked status");

  // Without a lock the rectangle origin falls back to zero.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rect_valid) |-> (out_rect_x == '0 && out_rect_y == '0))
    else $error("unlocked rectangle has a nonzero origin");

  // A rejected union restarts the count and leaves nothing locked.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status == ST_TOO_SMALL) |->
      (out_frames_accumulated == '0 && !out_rect_valid))
    else $error("too-small frame did not restart the accumulation");

  // Dark or incomplete frames are only reported before a lock.
  a_skip_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_frame_status == ST_DARK ||
                   out_frame_status == ST_EDGE_MISSING)) |-> !out_rect_valid)
    else $error("skipped frame reported with a locked rectangle");

endmodule

bind active_picture_area_detector apad_checker u_apad_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for active_picture_area_detector: sparse pixel frames
// against an in-bench model of the bound tracking, union and lock decision.
// Depends on apad_pkg and the detector RTL only.
`timescale 1ns / 100ps

module testbench;
  import apad_pkg::*;

  typedef struct {
    logic [LUMA_W-1:0]  blue;
    logic [LUMA_W-1:0]  green;
    logic [LUMA_W-1:0]  red;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } pixel_t;

  typedef struct {
    status_t            status;
    logic               rect_valid;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic [CNT_W-1:0]   frames;
  } frame_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [LUMA_W-1:0]     in_blue = '0;
  logic [LUMA_W-1:0]     in_green = '0;
  logic [LUMA_W-1:0]     in_red = '0;
  logic [COORD_W-1:0]    in_col = '0;
  logic [COORD_W-1:0]    in_row = '0;
  logic                  in_frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_frame_status;
  logic                  out_rect_valid;
  logic [COORD_W-1:0]    out_rect_x;
  logic [COORD_W-1:0]    out_rect_y;
  logic [DIM_W-1:0]      out_rect_w;
  logic [DIM_W-1:0]      out_rect_h;
  logic [CNT_W-1:0]      out_frames_accumulated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  active_picture_area_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .in_col(in_col), .in_row(in_row), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_status(out_frame_status), .out_rect_valid(out_rect_valid),
    .out_rect_x(out_rect_x), .out_rect_y(out_rect_y),
    .out_rect_w(out_rect_w), .out_rect_h(out_rect_h),
    .out_frames_accumulated(out_frames_accumulated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies, updated as each write is accepted.
  logic [DIM_W-1:0]  cfg_w     = FRAME_WIDTH_RST;
  logic [DIM_W-1:0]  cfg_h     = FRAME_HEIGHT_RST;
  logic [LUMA_W-1:0] cfg_thr   = LUMA_THRESH_RST;
  logic [DIM_W-1:0]  cfg_min_w = MIN_WIDTH_RST;
  logic [DIM_W-1:0]  cfg_min_h = MIN_HEIGHT_RST;
  logic [CNT_W-1:0]  cfg_accum = ACCUM_FRAMES_RST;

  // Per-frame bright bounds.
  bit          seen_light, top_hit, bot_hit, left_hit, right_hit;
  int unsigned top_y, bot_y, left_x, right_x;
  // Union over bright frames and the locked rectangle.
  int unsigned u_top, u_bot, u_left, u_right;
  int unsigned bright_frames;
  bit          rect_locked;
  int unsigned lock_x, lock_y, lock_w, lock_h;

  frame_report_t frame_reports[$];
  pixel_t        frame_px[$];
  int            mismatches = 0;
  int            pixels_sent = 0;
  bit            sender_steady;
  int            sink_left = 0;
  bit            sink_busy = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
  endfunction

  function automatic int unsigned band_depth(int unsigned size, int unsigned minv);
    return (size > minv) ? size - minv : 0;
  endfunction

  // Fold one accepted pixel into the running bounds of the current frame.
  function automatic void track_bright_pixel(pixel_t p);
    int unsigned w, h, xb, yb, luma, x, y;
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    xb = band_depth(w, cfg_min_w);
    yb = band_depth(h, cfg_min_h);
    luma = p.blue;
    if (p.green > luma) luma = p.green;
    if (p.red > luma) luma = p.red;
    x = p.col;
    y = p.row;
    if (x >= w || y >= h || luma <= cfg_thr) return;
    if (x % DARK_STEP_DEF == 0 && y % DARK_STEP_DEF == 0) seen_light = 1'b1;
    if (x % SAMPLE_STEP_DEF == 0) begin
      if (y <= yb && (!top_hit || y < top_y)) begin
        top_hit = 1'b1;
        top_y = y;
      end
      if (y + yb + 1 >= h && (!bot_hit || y > bot_y)) begin
        bot_hit = 1'b1;
        bot_y = y;
      end
    end
    if (y % SAMPLE_STEP_DEF == 0) begin
      if (x <= xb && (!left_hit || x < left_x)) begin
        left_hit = 1'b1;
        left_x = x;
      end
      if (x + xb + 1 >= w && (!right_hit || x > right_x)) begin
        right_hit = 1'b1;
        right_x = x;
      end
    end
  endfunction

  // Frame end: union the bounds, take the lock decision and build the report.
  function automatic frame_report_t close_frame();
    frame_report_t r;
    status_t       st;
    int            aw, ah;
    if (rect_locked) st = ST_LOCKED_ALREADY;
    else if (!seen_light) st = ST_DARK;
    else if (!(top_hit && bot_hit && left_hit && right_hit)) st = ST_EDGE_MISSING;
    else begin
      if (bright_frames == 0) begin
        u_top = top_y;
        u_bot = bot_y;
        u_left = left_x;
        u_right = right_x;
      end else begin
        if (top_y < u_top) u_top = top_y;
        if (bot_y > u_bot) u_bot = bot_y;
        if (left_x < u_left) u_left = left_x;
        if (right_x > u_right) u_right = right_x;
      end
      bright_frames = (bright_frames + 1) % 256;
      if (bright_frames < cfg_accum) st = ST_ACCUMULATED;
      else begin
        aw = int'(u_right) - int'(u_left) + 1;
        ah = int'(u_bot) - int'(u_top) + 1;
        if (aw >= 1 && ah >= 1 && aw >= int'(cfg_min_w) && ah >= int'(cfg_min_h)) begin
          rect_locked = 1'b1;
          lock_x = u_left & 'hFFF;
          lock_y = u_top & 'hFFF;
          lock_w = aw & 'h1FFF;
          lock_h = ah & 'h1FFF;
          st = ST_LOCKED_NOW;
        end else begin
          bright_frames = 0;
          st = ST_TOO_SMALL;
        end
      end
    end
    // The per-frame trackers clear on every frame end.
    seen_light = 1'b0;
    top_hit = 1'b0;
    bot_hit = 1'b0;
    left_hit = 1'b0;
    right_hit = 1'b0;
    top_y = 0;
    bot_y = 0;
    left_x = 0;
    right_x = 0;
    r.status = st;
    r.rect_valid = rect_locked;
    r.rect_x = COORD_W'(rect_locked ? lock_x : 0);
    r.rect_y = COORD_W'(rect_locked ? lock_y : 0);
    r.rect_w = DIM_W'(rect_locked ? lock_w : clamp_dim(cfg_w));
    r.rect_h = DIM_W'(rect_locked ? lock_h : clamp_dim(cfg_h));
    r.frames = CNT_W'(bright_frames);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [DIM_W-1:0] want,
                                        logic [DIM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result beats are checked against the oldest pending report; the sink
  // alternates random runs of stall and no stall.
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        $error("result beat with no frame end pending");
        mismatches++;
      end else begin
        want = frame_reports.pop_front();
        compare_field("frame_status", want.status, out_frame_status);
        compare_field("rect_valid", want.rect_valid, out_rect_valid);
        compare_field("rect_x", want.rect_x, out_rect_x);
        compare_field("rect_y", want.rect_y, out_rect_y);
        compare_field("rect_w", want.rect_w, out_rect_w);
        compare_field("rect_h", want.rect_h, out_rect_h);
        compare_field("frames_accumulated", want.frames, out_frames_accumulated);
      end
    end
    if (sink_left == 0) begin
      sink_busy = !sink_busy;
      if (sink_busy)
        sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      else
        sink_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
      out_stall <= sink_busy;
    end
    sink_left = sink_left - 1;
  end

  task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:    cfg_w = val;
      CFG_FRAME_HEIGHT:   cfg_h = val;
      CFG_LUMA_THRESHOLD: cfg_thr = val[LUMA_W-1:0];
      CFG_MIN_WIDTH:      cfg_min_w = val;
      CFG_MIN_HEIGHT:     cfg_min_h = val;
      CFG_ACCUM_FRAMES:   cfg_accum = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Stop the pixel stream and let every pending result and in-flight pixel drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned thr,
                            int unsigned mw, int unsigned mh, int unsigned acc);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
    write_reg(CFG_LUMA_THRESHOLD, DIM_W'(thr));
    write_reg(CFG_MIN_WIDTH, DIM_W'(mw));
    write_reg(CFG_MIN_HEIGHT, DIM_W'(mh));
    write_reg(CFG_ACCUM_FRAMES, DIM_W'(acc));
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    int unsigned r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one pixel beat, wait for it to be taken, then update the model.
  task automatic send_pixel(pixel_t p);
    int gap;
    in_valid <= 1'b1;
    in_blue <= p.blue;
    in_green <= p.green;
    in_red <= p.red;
    in_col <= p.col;
    in_row <= p.row;
    in_frame_end <= p.last;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    track_bright_pixel(p);
    if (p.last) frame_reports.push_back(close_frame());
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the collected pixels as one frame; the last one carries frame_end.
  task automatic send_frame();
    pixel_t p;
    sender_steady = ($urandom_range(0, 3) == 0);
    frame_px[frame_px.size() - 1].last = 1'b1;
    while (frame_px.size() != 0) begin
      p = frame_px.pop_front();
      send_pixel(p);
    end
  endtask

  function automatic void add_px(int unsigned x, int unsigned y, int unsigned b,
                                 int unsigned g, int unsigned r);
    pixel_t p;
    p.col = COORD_W'(x);
    p.row = COORD_W'(y);
    p.blue = LUMA_W'(b);
    p.green = LUMA_W'(g);
    p.red = LUMA_W'(r);
    p.last = 1'b0;
    frame_px.push_back(p);
  endfunction

  // A pixel at the given place, bright or dark against the current threshold.
  function automatic pixel_t rand_pixel(int unsigned x, int unsigned y, bit lit);
    pixel_t      p;
    int unsigned peak;
    p.col = COORD_W'(x);
    p.row = COORD_W'(y);
    p.last = 1'b0;
    if (lit && cfg_thr < 255) begin
      p.blue = LUMA_W'($urandom_range(0, 255));
      p.green = LUMA_W'($urandom_range(0, 255));
      p.red = LUMA_W'($urandom_range(0, 255));
      peak = $urandom_range(cfg_thr + 1, 255);
      case ($urandom_range(0, 2))
        0: p.blue = LUMA_W'(peak);
        1: p.green = LUMA_W'(peak);
        default: p.red = LUMA_W'(peak);
      endcase
    end else begin
      p.blue = LUMA_W'($urandom_range(0, cfg_thr));
      p.green = LUMA_W'($urandom_range(0, cfg_thr));
      p.red = LUMA_W'($urandom_range(0, cfg_thr));
    end
    return p;
  endfunction

  // A frame built from the current setting: a light-grid pixel, one pixel per
  // edge inside its band, some noise anywhere, all shuffled. Some frames lose
  // the light pixel or one edge. With hug set the edges sit on the frame border.
  task automatic random_frame(bit hug);
    int unsigned w, h, xb, yb, flaw, drop;
    int          j;
    pixel_t      tmp;
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    xb = band_depth(w, cfg_min_w);
    yb = band_depth(h, cfg_min_h);
    flaw = $urandom_range(0, 9);
    drop = (flaw == 1) ? $urandom_range(0, 3) : 4;
    if (flaw != 0)
      frame_px.push_back(rand_pixel(DARK_STEP_DEF * $urandom_range(0, (w - 1) / DARK_STEP_DEF),
                                    DARK_STEP_DEF * $urandom_range(0, (h - 1) / DARK_STEP_DEF),
                                    1'b1));
    if (drop != 0)
      frame_px.push_back(rand_pixel(hug ? 0 : $urandom_range(0, xb),
                                    SAMPLE_STEP_DEF * $urandom_range(0, (h - 1) / SAMPLE_STEP_DEF),
                                    1'b1));
    if (drop != 1)
      frame_px.push_back(rand_pixel(hug ? w - 1 : $urandom_range(w - 1 - xb, w - 1),
                                    SAMPLE_STEP_DEF * $urandom_range(0, (h - 1) / SAMPLE_STEP_DEF),
                                    1'b1));
    if (drop != 2)
      frame_px.push_back(rand_pixel(SAMPLE_STEP_DEF * $urandom_range(0, (w - 1) / SAMPLE_STEP_DEF),
                                    hug ? 0 : $urandom_range(0, yb), 1'b1));
    if (drop != 3)
      frame_px.push_back(rand_pixel(SAMPLE_STEP_DEF * $urandom_range(0, (w - 1) / SAMPLE_STEP_DEF),
                                    hug ? h - 1 : $urandom_range(h - 1 - yb, h - 1), 1'b1));
    repeat ($urandom_range(0, 4))
      frame_px.push_back(rand_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    ($urandom_range(0, 1) != 0)));
    for (int i = frame_px.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = frame_px[i];
      frame_px[i] = frame_px[j];
      frame_px[j] = tmp;
    end
    frame_px.push_back(rand_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                                  ($urandom_range(0, 1) != 0)));
    send_frame();
  endtask

  // Reset setting: a pixel exactly at threshold is dark, and a frame with
  // only the top-left corner lit misses edges.
  task automatic test_reset_state();
    add_px(0, 0, 40, 40, 40);
    send_frame();
    add_px(0, 0, 0, 0, 255);
    add_px(4095, 4095, 255, 255, 255);
    send_frame();
  endtask

  // Each channel alone sets the luma. A 64x64 frame below the minimum width
  // is too small at once with zero frames to accumulate, and after the second
  // frame with two.
  task automatic test_luma_and_accumulate();
    set_config(64, 64, 100, 65, 64, 0);
    add_px(63, 0, 100, 100, 100);
    add_px(0, 0, 255, 0, 0);
    add_px(63, 60, 0, 255, 0);
    add_px(60, 63, 0, 0, 255);
    send_frame();
    set_config(64, 64, 100, 65, 64, 2);
    repeat (2) begin
      add_px(0, 0, 255, 0, 0);
      add_px(63, 60, 0, 255, 0);
      add_px(60, 63, 0, 0, 255);
      send_frame();
    end
  endtask

  // Width above the maximum is clamped: column 4095 lies inside the frame.
  task automatic test_oversized_frame();
    set_config(8191, 4096, 0, 4096, 4096, 1);
    add_px(0, 0, 0, 1, 0);
    add_px(4095, 4092, 255, 0, 0);
    send_frame();
  endtask

  // Zero width or height leaves every frame dark, as does the top threshold.
  task automatic test_zero_size();
    set_config(0, 4096, 0, 1, 1, 255);
    add_px(0, 0, 255, 255, 255);
    send_frame();
    set_config(1, 0, 0, 1, 1, 255);
    add_px(0, 0, 255, 255, 255);
    send_frame();
    set_config(64, 64, 255, 1, 1, 255);
    add_px(0, 0, 255, 255, 255);
    send_frame();
  endtask

  // Settings where the union can never reach the minimum size, so the
  // accumulate and restart cycle runs without locking.
  task automatic test_random_unlockable();
    int unsigned w, h, mw, mh, acc, r;
    while (pixels_sent < 300) begin
      w = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 4095);
      if ($urandom_range(0, 3) == 0) h = $urandom_range(4097, 8191);
      else h = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 4095);
      mw = $urandom_range(1, 4096);
      mh = $urandom_range(1, 4096);
      if (h > MAX_DIM_DEF || $urandom_range(0, 1)) mw = $urandom_range(w + 1, 4096);
      else mh = $urandom_range(h + 1, 4096);
      r = $urandom_range(0, 9);
      if (r < 7) acc = $urandom_range(0, 4);
      else if (r < 9) acc = $urandom_range(5, 12);
      else acc = $urandom_range(13, 255);
      set_config(w, h, $urandom_range(0, 254), mw, mh, acc);
      repeat ($urandom_range(3, 10)) random_frame($urandom_range(0, 3) == 0);
    end
  endtask

  // A setting that can lock; up to 30 frames until it does, then a few more.
  task automatic test_random_lock();
    int unsigned w, h;
    int          tries;
    w = $urandom_range(64, 600);
    h = $urandom_range(64, 400);
    set_config(w, h, $urandom_range(0, 200), $urandom_range(w / 2, w),
               $urandom_range(h / 2, h), $urandom_range(1, 3));
    for (tries = 0; tries < 30 && !rect_locked; tries++)
      random_frame(tries > 10 || $urandom_range(0, 2) == 0);
    repeat (4) random_frame($urandom_range(0, 1) != 0);
  endtask

  // A full 64x64 frame locks if nothing has yet; the rectangle then holds
  // through a new setting.
  task automatic test_lock_and_hold();
    set_config(64, 64, 10, 64, 64, 1);
    add_px(0, 0, 255, 255, 255);
    add_px(63, 60, 255, 255, 255);
    add_px(60, 63, 255, 255, 255);
    send_frame();
    set_config(4096, 4096, 30, $urandom_range(1, 4096), $urandom_range(1, 4096),
               $urandom_range(1, 255));
    repeat (3) random_frame($urandom_range(0, 1) != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_luma_and_accumulate();
    test_oversized_frame();
    test_zero_size();
    test_random_unlockable();
    test_random_lock();
    test_lock_and_hold();
    wait_idle();
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
